>>> design/ogg_first_page_codec_sniffer_top_assert.svh
// assertion macros for the ogg first page codec sniffer
// included by the top level, no other dependencies
`ifndef OGG_FIRST_PAGE_CODEC_SNIFFER_TOP_ASSERT_SVH
`define OGG_FIRST_PAGE_CODEC_SNIFFER_TOP_ASSERT_SVH

// condition holds in the same cycle
`define OGG_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ogg sniffer assertion failed");

// condition holds in the following cycle
`define OGG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ogg sniffer assertion failed");

`endif

>>> design/ogg_fpcs_pkg.sv
// shared types, codes and signature tables for the ogg first page codec sniffer
// no dependencies
package ogg_fpcs_pkg;

    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_END     = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    localparam logic [1:0] VERDICT_VORBIS  = 2'd0;
    localparam logic [1:0] VERDICT_OPUS    = 2'd1;
    localparam logic [1:0] VERDICT_UNKNOWN = 2'd2;
    localparam logic [1:0] VERDICT_ERROR   = 2'd3;

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_SEGTAB  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_DONE    = 2'd3;

    localparam logic [4:0] HDR_VERSION_POS = 5'd4;
    localparam logic [4:0] HDR_TYPE_POS    = 5'd5;
    localparam logic [4:0] HDR_SEGCNT_POS  = 5'd26;
    localparam logic [7:0] HDR_VERSION     = 8'h00;
    localparam logic [7:0] HDR_TYPE_BOS    = 8'h02;

    localparam logic [15:0] MIN_LEN_OPUS   = 16'd8;
    localparam logic [15:0] MIN_LEN_VORBIS = 16'd7;
    localparam logic [15:0] VORBIS_SIG_LEN = 16'd7;
    localparam logic [15:0] OPUS_SIG_LEN   = 16'd8;

    typedef struct packed {
        logic       valid;
        logic [1:0] verdict;
    } t_result;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h4F;
            2'd1:    b = 8'h67;
            2'd2:    b = 8'h67;
            default: b = 8'h53;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] vorbis_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h01;
            3'd1:    b = 8'h76;
            3'd2:    b = 8'h6f;
            3'd3:    b = 8'h72;
            3'd4:    b = 8'h62;
            3'd5:    b = 8'h69;
            3'd6:    b = 8'h73;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] opus_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h4f;
            3'd1:    b = 8'h70;
            3'd2:    b = 8'h75;
            3'd3:    b = 8'h73;
            3'd4:    b = 8'h48;
            3'd5:    b = 8'h65;
            3'd6:    b = 8'h61;
            default: b = 8'h64;
        endcase
        return b;
    endfunction

endpackage

>>> design/ogg_fpcs_parse.sv
// page header, segment table and signature tracking for the sniffer
// depends on ogg_fpcs_pkg
module ogg_fpcs_parse (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [1:0]            i_kind,
    input  logic [7:0]            i_byte_value,
    input  logic                  i_opus_enable,
    output ogg_fpcs_pkg::t_result o_result
);

    logic [4:0]  r_hdr_pos, n_hdr_pos;
    logic [7:0]  r_segs_left, n_segs_left;
    logic [15:0] r_pay_len, n_pay_len;
    logic [15:0] r_pay_pos, n_pay_pos;
    logic [1:0]  r_phase, n_phase;
    logic        r_vorbis_ok, n_vorbis_ok;
    logic        r_opus_ok, n_opus_ok;

    always_comb begin
        logic [15:0] need;
        need = i_opus_enable ? ogg_fpcs_pkg::MIN_LEN_OPUS : ogg_fpcs_pkg::MIN_LEN_VORBIS;
        n_hdr_pos        = r_hdr_pos;
        n_segs_left      = r_segs_left;
        n_pay_len        = r_pay_len;
        n_pay_pos        = r_pay_pos;
        n_phase          = r_phase;
        n_vorbis_ok      = r_vorbis_ok;
        n_opus_ok        = r_opus_ok;
        o_result.valid   = 1'b0;
        o_result.verdict = ogg_fpcs_pkg::VERDICT_ERROR;
        if (i_accept) begin
            case (i_kind)
                ogg_fpcs_pkg::KIND_RESTART: begin
                    n_hdr_pos   = '0;
                    n_segs_left = '0;
                    n_pay_len   = '0;
                    n_pay_pos   = '0;
                    n_phase     = ogg_fpcs_pkg::PH_HEADER;
                    n_vorbis_ok = 1'b1;
                    n_opus_ok   = 1'b1;
                end
                ogg_fpcs_pkg::KIND_END: begin
                    if (r_phase != ogg_fpcs_pkg::PH_DONE) begin
                        o_result.valid = 1'b1;
                        n_phase        = ogg_fpcs_pkg::PH_DONE;
                    end
                end
                ogg_fpcs_pkg::KIND_DATA: begin
                    case (r_phase)
                        ogg_fpcs_pkg::PH_HEADER: begin
                            n_hdr_pos = r_hdr_pos + 5'd1;
                            if (r_hdr_pos < 5'd4 &&
                                i_byte_value != ogg_fpcs_pkg::magic_byte(r_hdr_pos[1:0])) begin
                                o_result.valid = 1'b1;
                            end
                            if (r_hdr_pos == ogg_fpcs_pkg::HDR_VERSION_POS &&
                                i_byte_value != ogg_fpcs_pkg::HDR_VERSION) begin
                                o_result.valid = 1'b1;
                            end
                            if (r_hdr_pos == ogg_fpcs_pkg::HDR_TYPE_POS &&
                                i_byte_value != ogg_fpcs_pkg::HDR_TYPE_BOS) begin
                                o_result.valid = 1'b1;
                            end
                            if (r_hdr_pos == ogg_fpcs_pkg::HDR_SEGCNT_POS) begin
                                if (i_byte_value == 8'd0) begin
                                    o_result.valid = 1'b1;
                                end else begin
                                    n_segs_left = i_byte_value;
                                    n_pay_len   = '0;
                                    n_phase     = ogg_fpcs_pkg::PH_SEGTAB;
                                end
                            end
                            if (o_result.valid) begin
                                n_hdr_pos = r_hdr_pos;
                                n_phase   = ogg_fpcs_pkg::PH_DONE;
                            end
                        end
                        ogg_fpcs_pkg::PH_SEGTAB: begin
                            n_pay_len   = r_pay_len + {8'd0, i_byte_value};
                            n_segs_left = r_segs_left - 8'd1;
                            if (n_segs_left == 8'd0) begin
                                if (n_pay_len < need) begin
                                    o_result.valid = 1'b1;
                                    n_phase        = ogg_fpcs_pkg::PH_DONE;
                                end else begin
                                    n_pay_pos = '0;
                                    n_phase   = ogg_fpcs_pkg::PH_PAYLOAD;
                                end
                            end
                        end
                        ogg_fpcs_pkg::PH_PAYLOAD: begin
                            if (r_pay_pos < ogg_fpcs_pkg::VORBIS_SIG_LEN &&
                                i_byte_value != ogg_fpcs_pkg::vorbis_byte(r_pay_pos[2:0])) begin
                                n_vorbis_ok = 1'b0;
                            end
                            if (r_pay_pos < ogg_fpcs_pkg::OPUS_SIG_LEN &&
                                i_byte_value != ogg_fpcs_pkg::opus_byte(r_pay_pos[2:0])) begin
                                n_opus_ok = 1'b0;
                            end
                            n_pay_pos = r_pay_pos + 16'd1;
                            if (n_pay_pos >= r_pay_len) begin
                                o_result.valid = 1'b1;
                                n_phase        = ogg_fpcs_pkg::PH_DONE;
                                if (n_vorbis_ok) begin
                                    o_result.verdict = ogg_fpcs_pkg::VERDICT_VORBIS;
                                end else if (i_opus_enable && n_opus_ok) begin
                                    o_result.verdict = ogg_fpcs_pkg::VERDICT_OPUS;
                                end else begin
                                    o_result.verdict = ogg_fpcs_pkg::VERDICT_UNKNOWN;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_pos   <= '0;
            r_segs_left <= '0;
            r_pay_len   <= '0;
            r_pay_pos   <= '0;
            r_phase     <= ogg_fpcs_pkg::PH_HEADER;
            r_vorbis_ok <= 1'b1;
            r_opus_ok   <= 1'b1;
        end else begin
            r_hdr_pos   <= n_hdr_pos;
            r_segs_left <= n_segs_left;
            r_pay_len   <= n_pay_len;
            r_pay_pos   <= n_pay_pos;
            r_phase     <= n_phase;
            r_vorbis_ok <= n_vorbis_ok;
            r_opus_ok   <= n_opus_ok;
        end
    end

endmodule

>>> design/ogg_first_page_codec_sniffer_top.sv
// ogg first page codec sniffer: one request per cycle, no request stalls on parsing
// a verdict is registered in the output slot, or in the skid slot while the output slot waits
// a two-deep verdict buffer parts the sides; input stalls only while both slots wait
// synchronous active-low reset: header phase, opus detection enabled, buffer empty
// depends on ogg_fpcs_pkg, ogg_fpcs_parse and the assertion macro header
module ogg_first_page_codec_sniffer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_byte_value,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_codec_verdict,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data
);

    `include "ogg_first_page_codec_sniffer_top_assert.svh"

    logic                 r_opus_enable;
    logic                 r_out_valid;
    logic [1:0]           r_out_verdict;
    logic                 r_skid_valid;
    logic [1:0]           r_skid_verdict;
    logic                 w_accept;
    logic                 w_out_take;
    ogg_fpcs_pkg::t_result w_res;

    assign o_in_stall      = r_skid_valid;
    assign w_accept        = i_in_valid && !r_skid_valid;
    assign w_out_take      = r_out_valid && !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_codec_verdict = r_out_verdict;

    ogg_fpcs_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_kind       (i_kind),
        .i_byte_value (i_byte_value),
        .i_opus_enable(r_opus_enable),
        .o_result     (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opus_enable <= 1'b1;
        end else if (i_cfg_we) begin
            r_opus_enable <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || w_out_take) begin
            r_out_valid <= w_res.valid;
        end else if (w_res.valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_take) begin
                r_out_verdict <= r_skid_verdict;
            end
        end else if (!r_out_valid || w_out_take) begin
            r_out_verdict <= w_res.verdict;
        end else if (w_res.valid) begin
            r_skid_verdict <= w_res.verdict;
        end
    end

    // skid slot only fills behind a waiting verdict
    `OGG_ASSERT_IMPLY(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    // no new verdict while both slots are occupied
    `OGG_ASSERT_IMPLY(a_no_res_when_full, i_clk, i_rst_n, w_res.valid, !r_skid_valid)
    // a taken verdict frees the skid slot
    `OGG_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, r_skid_valid && !i_out_stall,
        !r_skid_valid && r_out_valid)

endmodule

>>> dv/ogg_codec_verdict_checker.sv
// watches both channels and the register port of the ogg first page codec sniffer,
// predicts the codec verdict of every stream and compares it with what comes out
// depends on ogg_fpcs_pkg
module ogg_codec_verdict_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_byte_value,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [1:0] i_codec_verdict,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    output int         o_fail_count,
    output int         o_verdicts_due,
    output int         o_verdicts_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] OGG_MAGIC  = 32'h4F676753;
    localparam logic [55:0] VORBIS_SIG = 56'h01766f72626973;
    localparam logic [63:0] OPUS_SIG   = 64'h4f707573_48656164;

    logic        opus_on;
    logic [4:0]  hdr_pos;
    logic [7:0]  seg_left;
    logic [15:0] pay_len;
    logic [15:0] pay_pos;
    logic [1:0]  phase;
    logic        vorbis_ok;
    logic        opus_ok;
    logic        decided;
    logic [1:0]  verdict_q[$];

    task automatic clear_stream();
        hdr_pos   = '0;
        seg_left  = '0;
        pay_len   = '0;
        pay_pos   = '0;
        phase     = ogg_fpcs_pkg::PH_HEADER;
        vorbis_ok = 1'b1;
        opus_ok   = 1'b1;
        decided   = 1'b0;
    endtask

    task automatic give_verdict(input logic [1:0] v);
        verdict_q.push_back(v);
        decided = 1'b1;
        phase   = ogg_fpcs_pkg::PH_DONE;
    endtask

    task automatic sniff_codec(input logic [1:0] k, input logic [7:0] b);
        int p;
        int q;
        logic [15:0] need;
        p = hdr_pos;
        q = pay_pos;
        if (k == ogg_fpcs_pkg::KIND_RESTART) begin
            clear_stream();
        end else if (decided
                || (k != ogg_fpcs_pkg::KIND_DATA && k != ogg_fpcs_pkg::KIND_END)) begin
            // nothing happens: a decided stream waits for a restart, other kinds are ignored
        end else if (k == ogg_fpcs_pkg::KIND_END) begin
            give_verdict(ogg_fpcs_pkg::VERDICT_ERROR);
        end else begin
            case (phase)
                ogg_fpcs_pkg::PH_HEADER: begin
                    if ((p < 4 && b != OGG_MAGIC[31 - 8 * p -: 8])
                            || (hdr_pos == ogg_fpcs_pkg::HDR_VERSION_POS
                                && b != ogg_fpcs_pkg::HDR_VERSION)
                            || (hdr_pos == ogg_fpcs_pkg::HDR_TYPE_POS
                                && b != ogg_fpcs_pkg::HDR_TYPE_BOS)
                            || (hdr_pos == ogg_fpcs_pkg::HDR_SEGCNT_POS && b == 8'd0)) begin
                        give_verdict(ogg_fpcs_pkg::VERDICT_ERROR);
                    end else begin
                        if (hdr_pos == ogg_fpcs_pkg::HDR_SEGCNT_POS) begin
                            seg_left = b;
                            pay_len  = '0;
                            phase    = ogg_fpcs_pkg::PH_SEGTAB;
                        end
                        hdr_pos = hdr_pos + 5'd1;
                    end
                end
                ogg_fpcs_pkg::PH_SEGTAB: begin
                    pay_len  = pay_len + {8'd0, b};
                    seg_left = seg_left - 8'd1;
                    if (seg_left == 8'd0) begin
                        need = opus_on ? ogg_fpcs_pkg::MIN_LEN_OPUS
                                       : ogg_fpcs_pkg::MIN_LEN_VORBIS;
                        if (pay_len < need) begin
                            give_verdict(ogg_fpcs_pkg::VERDICT_ERROR);
                        end else begin
                            pay_pos = '0;
                            phase   = ogg_fpcs_pkg::PH_PAYLOAD;
                        end
                    end
                end
                ogg_fpcs_pkg::PH_PAYLOAD: begin
                    if (q < ogg_fpcs_pkg::VORBIS_SIG_LEN && b != VORBIS_SIG[55 - 8 * q -: 8])
                        vorbis_ok = 1'b0;
                    if (q < ogg_fpcs_pkg::OPUS_SIG_LEN && b != OPUS_SIG[63 - 8 * q -: 8])
                        opus_ok = 1'b0;
                    pay_pos = pay_pos + 16'd1;
                    if (pay_pos >= pay_len) begin
                        if (vorbis_ok)
                            give_verdict(ogg_fpcs_pkg::VERDICT_VORBIS);
                        else if (opus_on && opus_ok)
                            give_verdict(ogg_fpcs_pkg::VERDICT_OPUS);
                        else
                            give_verdict(ogg_fpcs_pkg::VERDICT_UNKNOWN);
                    end
                end
                default: begin
                end
            endcase
        end
    endtask

    always @(posedge i_clk) begin : watch
        logic [1:0] want;
        if (!i_rst_n) begin
            opus_on = 1'b1;
            clear_stream();
            verdict_q.delete();
            o_fail_count    = 0;
            o_verdicts_seen = 0;
        end else begin
            if (i_cfg_we)
                opus_on = i_cfg_data;
            if (i_in_valid && !i_in_stall)
                sniff_codec(i_kind, i_byte_value);
            if (i_out_valid && !i_out_stall) begin
                o_verdicts_seen++;
                if (verdict_q.size() == 0) begin
                    $error("codec_verdict: none expected, got %0d", i_codec_verdict);
                    o_fail_count++;
                end else begin
                    want = verdict_q.pop_front();
                    if (i_codec_verdict !== want) begin
                        $error("codec_verdict: expected %0d, got %0d", want, i_codec_verdict);
                        o_fail_count++;
                    end
                end
            end
        end
        o_verdicts_due = verdict_q.size();
    end

endmodule

>>> dv/tb_ogg_first_page_codec_sniffer_top.sv
// stimulus and verdict for the ogg first page codec sniffer: directed pages, then
// random pages, broken pages and noise under both register settings
// depends on ogg_fpcs_pkg, ogg_first_page_codec_sniffer_top and ogg_codec_verdict_checker
module tb_ogg_first_page_codec_sniffer_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 10;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 8;
    localparam int ITEM_TARGET    = 2000;
    localparam int QUIET_FROM     = 1750;

    localparam logic [1:0]  KIND_UNUSED = 2'd3;
    localparam logic [31:0] OGG_MAGIC   = 32'h4F676753;
    localparam logic [55:0] VORBIS_SIG  = 56'h01766f72626973;
    localparam logic [63:0] OPUS_SIG    = 64'h4f707573_48656164;

    typedef enum int {SIG_VORBIS, SIG_OPUS, SIG_NOISE, SIG_NEAR} page_sig_e;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic       out_valid;
    logic       out_stall;
    logic [1:0] codec_verdict;
    logic       cfg_we;
    logic       cfg_data;

    int fail_total;
    int verdicts_due;
    int verdicts_seen;

    logic [7:0] page_q[$];
    int items_sent = 0;
    int calm_left = 0;
    bit quiet = 1'b0;
    bit hold_go = 1'b0;
    bit hold_taken = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    ogg_first_page_codec_sniffer_top dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_kind         (kind),
        .i_byte_value   (byte_value),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_codec_verdict(codec_verdict),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data)
    );

    ogg_codec_verdict_checker checker_i (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_kind         (kind),
        .i_byte_value   (byte_value),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_codec_verdict(codec_verdict),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_total),
        .o_verdicts_due (verdicts_due),
        .o_verdicts_seen(verdicts_seen)
    );

    function automatic logic [7:0] rand_byte();
        logic [31:0] r;
        r = $urandom;
        return r[7:0];
    endfunction

    function automatic logic [1:0] rand_kind();
        logic [31:0] r;
        r = $urandom;
        return r[1:0];
    endfunction

    task automatic send_req(input logic [1:0] k, input logic [7:0] b);
        if (!quiet && calm_left == 0 && $urandom_range(0, 7) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
            calm_left = $urandom_range(0, 40);
        end else if (calm_left > 0) begin
            calm_left--;
        end
        in_valid   = 1'b1;
        kind       = k;
        byte_value = b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (k != KIND_UNUSED)
            items_sent++;
        @(negedge clk);
    endtask

    task automatic send_span(input int lo, input int hi);
        int i;
        for (i = lo; i < hi; i++)
            send_req(ogg_fpcs_pkg::KIND_DATA, page_q[i]);
    endtask

    task automatic build_page(input page_sig_e sig, input int seg_n, input int seg_max,
                              input int fixed_len);
        int total;
        int v;
        int k;
        int head_len;
        int miss;
        logic [63:0] head;
        page_q.delete();
        for (k = 0; k < 4; k++)
            page_q.push_back(OGG_MAGIC[31 - 8 * k -: 8]);
        page_q.push_back(ogg_fpcs_pkg::HDR_VERSION);
        page_q.push_back(ogg_fpcs_pkg::HDR_TYPE_BOS);
        for (k = 6; k < 26; k++)
            page_q.push_back(rand_byte());
        page_q.push_back(seg_n[7:0]);
        total = 0;
        for (k = 0; k < seg_n; k++) begin
            if (fixed_len >= 0)
                v = (k == 0) ? fixed_len : 0;
            else
                v = $urandom_range(0, seg_max);
            page_q.push_back(v[7:0]);
            total += v;
        end
        head_len = 8;
        case (sig)
            SIG_VORBIS: begin
                head     = {VORBIS_SIG, 8'h00};
                head_len = 7;
            end
            SIG_OPUS: begin
                head = OPUS_SIG;
            end
            SIG_NOISE: begin
                head = {$urandom, $urandom};
            end
            default: begin
                if ($urandom_range(0, 1) == 0) begin
                    head     = {VORBIS_SIG, 8'h00};
                    head_len = 7;
                end else begin
                    head = OPUS_SIG;
                end
                miss = $urandom_range(0, head_len - 1);
                head[63 - 8 * miss -: 8] = head[63 - 8 * miss -: 8] ^ (rand_byte() | 8'h01);
            end
        endcase
        for (k = 0; k < total; k++)
            page_q.push_back((k < head_len) ? head[63 - 8 * k -: 8] : rand_byte());
    endtask

    task automatic run_page(input page_sig_e sig, input int seg_n, input int seg_max,
                            input int fixed_len);
        send_req(ogg_fpcs_pkg::KIND_RESTART, rand_byte());
        build_page(sig, seg_n, seg_max, fixed_len);
        send_span(0, page_q.size());
    endtask

    task automatic settle();
        in_valid = 1'b0;
        while (verdicts_due != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_opus(input logic v);
        settle();
        cfg_data = v;
        cfg_we   = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic random_traffic(input int until_items);
        int r;
        int cut;
        int n;
        int k;
        page_sig_e sig;
        while (items_sent < until_items) begin
            if (items_sent >= QUIET_FROM)
                quiet = 1'b1;
            r   = $urandom_range(0, 99);
            sig = page_sig_e'($urandom_range(0, 3));
            if (r < 65) begin
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 255) : $urandom_range(1, 4);
                run_page(sig, n, (n > 4) ? 2 : (($urandom_range(0, 9) == 0) ? 255 : 12), -1);
                if ($urandom_range(0, 2) == 0)
                    for (k = $urandom_range(1, 3); k > 0; k--)
                        send_req(rand_kind(), rand_byte());
            end else if (r < 85) begin
                send_req(ogg_fpcs_pkg::KIND_RESTART, rand_byte());
                build_page(sig, $urandom_range(1, 4), 12, -1);
                cut = $urandom_range(0, page_q.size() - 1);
                case ($urandom_range(0, 3))
                    0: begin
                        cut = $urandom_range(0, 6);
                        if (cut == 6)
                            cut = ogg_fpcs_pkg::HDR_SEGCNT_POS;
                        page_q[cut] = page_q[cut] ^ (rand_byte() | 8'h01);
                        send_span(0, page_q.size());
                    end
                    1: begin
                        send_span(0, cut);
                        send_req(ogg_fpcs_pkg::KIND_END, rand_byte());
                    end
                    2: begin
                        send_span(0, cut);
                        send_req(ogg_fpcs_pkg::KIND_RESTART, rand_byte());
                    end
                    default: begin
                        send_span(0, cut);
                        send_req(KIND_UNUSED, rand_byte());
                        send_span(cut, page_q.size());
                    end
                endcase
            end else begin
                for (k = $urandom_range(1, 6); k > 0; k--)
                    send_req(rand_kind(), rand_byte());
            end
        end
    endtask

    initial begin : receiver
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_go && !hold_taken) begin
                hold_taken = 1'b1;
                out_stall  = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall = 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 18)) @(negedge clk);
                out_stall = 1'b0;
                repeat ($urandom_range(0, 30)) @(negedge clk);
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $error("no request or verdict moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        int p;
        int pos;
        int ph;
        int k;
        logic [31:0] r32;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        kind       = ogg_fpcs_pkg::KIND_DATA;
        byte_value = 8'h00;
        cfg_we     = 1'b0;
        cfg_data   = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        run_page(SIG_VORBIS, 1, 0, 8);
        run_page(SIG_OPUS, 2, 0, 8);
        run_page(SIG_OPUS, 1, 0, 7);
        run_page(SIG_NOISE, 255, 0, 10);
        run_page(SIG_NEAR, 3, 255, -1);

        // bad magic, version, page type and zero segment count, then bytes after the verdict
        for (p = 0; p < 7; p++) begin
            send_req(ogg_fpcs_pkg::KIND_RESTART, rand_byte());
            build_page(SIG_VORBIS, 1, 0, 8);
            pos = (p == 6) ? ogg_fpcs_pkg::HDR_SEGCNT_POS : p;
            page_q[pos] = (p == 6) ? 8'h00 : (page_q[pos] ^ 8'hFF);
            send_span(0, pos + 2);
            send_req(ogg_fpcs_pkg::KIND_END, rand_byte());
        end

        send_req(ogg_fpcs_pkg::KIND_RESTART, rand_byte());
        build_page(SIG_OPUS, 1, 0, 8);
        send_span(0, 10);
        send_req(ogg_fpcs_pkg::KIND_END, rand_byte());

        send_req(ogg_fpcs_pkg::KIND_RESTART, rand_byte());
        build_page(SIG_OPUS, 1, 0, 8);
        send_span(0, 27);
        send_req(KIND_UNUSED, 8'hFF);
        send_span(27, page_q.size());

        send_req(ogg_fpcs_pkg::KIND_RESTART, rand_byte());
        build_page(SIG_VORBIS, 2, 0, 40);
        send_span(0, 35);
        send_req(ogg_fpcs_pkg::KIND_RESTART, rand_byte());
        build_page(SIG_VORBIS, 1, 0, 20);
        send_span(0, 33);
        send_req(ogg_fpcs_pkg::KIND_END, rand_byte());

        set_opus(1'b0);
        run_page(SIG_VORBIS, 1, 0, 7);
        run_page(SIG_OPUS, 1, 0, 8);
        run_page(SIG_NOISE, 1, 0, 6);

        // register flips while the payload is arriving
        send_req(ogg_fpcs_pkg::KIND_RESTART, rand_byte());
        build_page(SIG_OPUS, 1, 0, 7);
        send_span(0, 31);
        set_opus(1'b1);
        send_span(31, page_q.size());
        send_req(ogg_fpcs_pkg::KIND_RESTART, rand_byte());
        build_page(SIG_OPUS, 1, 0, 8);
        send_span(0, 32);
        set_opus(1'b0);
        send_span(32, page_q.size());

        for (ph = 0; ph < 4; ph++) begin
            r32 = $urandom;
            set_opus((ph == 2) ? r32[0] : ph[0]);
            if (ph == 1) begin
                hold_go = 1'b1;
                while (!hold_taken) @(negedge clk);
                for (k = 0; k < 40; k++) begin
                    send_req(ogg_fpcs_pkg::KIND_END, rand_byte());
                    send_req(ogg_fpcs_pkg::KIND_RESTART, rand_byte());
                end
            end
            random_traffic((ph + 1) * ITEM_TARGET / 4);
        end

        in_valid = 1'b0;
        while (verdicts_due != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("covered %0d requests and %0d verdicts over both opus settings", items_sent,
                 verdicts_seen);
        $display("including broken headers, early ends, restarts and a long output hold");
        if (fail_total == 0 && verdicts_due == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> ogg_first_page_codec_sniffer_top.f
+incdir+design
design/ogg_fpcs_pkg.sv
design/ogg_fpcs_parse.sv
design/ogg_first_page_codec_sniffer_top.sv
dv/ogg_codec_verdict_checker.sv
dv/tb_ogg_first_page_codec_sniffer_top.sv
